// ----- src/ipc_pkg.sv -----
// Shared types and constants for the isolated pixel counter.
`default_nettype none

package ipc_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_W      = 15;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [PIX_W-1:0] STAR_CODE    = 8'd42;
  localparam logic [CNT_W-1:0] COUNT_MAX    = 15'h7FFF;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 8'd100;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 8'd100;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic iso;
    logic star;
  } flag_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } geom_t;

  function automatic flag_t clear_iso(flag_t f);
    flag_t r;
    r     = f;
    r.iso = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/ipc_if.sv -----
// Handshake interfaces for the pixel input channel and the count result channel.
`default_nettype none

interface ipc_pixel_if;
  import ipc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_byte;
  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

interface ipc_result_if;
  import ipc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] isolated_count;
  logic             frame_done;
  modport source (output valid, output isolated_count, output frame_done, input ready);
  modport sink (input valid, input isolated_count, input frame_done, output ready);
endinterface

`default_nettype wire

// ----- src/ipc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module ipc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/ipc_cfg.sv -----
// APB register file holding the image geometry.
`default_nettype none

module ipc_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ipc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [ipc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [ipc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  output ipc_pkg::geom_t                          geom_o
);
  import ipc_pkg::*;

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  reg_idx_e         addr_idx;
  logic             wr_en;

  assign addr_idx = reg_idx_e'(paddr[2]);
  assign wr_en    = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (addr_idx)
        REG_WIDTH: begin
          width_q <= pwdata[CFG_W-1:0];
        end
        REG_HEIGHT: begin
          height_q <= pwdata[CFG_W-1:0];
        end
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  always_comb begin
    case (addr_idx)
      REG_WIDTH: begin
        prdata = {{(APB_DATA_W-CFG_W){1'b0}}, width_q};
      end
      REG_HEIGHT: begin
        prdata = {{(APB_DATA_W-CFG_W){1'b0}}, height_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign geom_o.width  = width_q;
  assign geom_o.height = height_q;

endmodule

`default_nettype wire

// ----- src/ipc_core.sv -----
// Raster update engine: line-store access, neighbor window, running count and result register.
`default_nettype none

module ipc_core #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ipc_pkg::geom_t geom_i,
  ipc_pixel_if.sink      pix,
  ipc_result_if.source   res
);
  import ipc_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned EWW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int unsigned EWH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CW-1:0]    prev_col_q;
  flag_t            left_q;
  flag_t            hold_q;
  flag_t            up_q;
  flag_t            head0_q;
  flag_t            head1_q;
  flag_t            ur_head_q;
  logic             use_head_q;
  logic             byp_q;
  flag_t            byp_data_q;
  logic             out_valid_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_done_q;

  logic [EWW-1:0]   w_ext;
  logic [EWH-1:0]   h_ext;
  logic [CW-1:0]    last_c;
  logic [RW-1:0]    last_r;
  logic             acc;
  logic             star;
  logic             c_first;
  logic             up_ok;
  logic             last_col;
  logic             last_row;
  flag_t            ram_rdata;
  flag_t            ur_raw;
  flag_t            left;
  flag_t            ul;
  flag_t            up;
  flag_t            ur;
  flag_t            fresh;
  flag_t            wr_data;
  flag_t            up_w;
  flag_t            ur_w;
  flag_t            final0;
  flag_t            final1;
  logic             any_star;
  logic             inc;
  logic [2:0]       n_dec;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] cnt_new;
  logic [CW-1:0]    rd_addr;
  logic             is_col1;
  logic             is_col2;

  always_comb begin
    w_ext = EWW'(geom_i.width);
    h_ext = EWH'(geom_i.height);
    if (w_ext == '0) begin
      last_c = '0;
    end else if (w_ext > EWW'(MAX_WIDTH)) begin
      last_c = CW'(MAX_WIDTH - 1);
    end else begin
      last_c = CW'(w_ext - 1'b1);
    end
    if (h_ext == '0) begin
      last_r = '0;
    end else if (h_ext > EWH'(MAX_HEIGHT)) begin
      last_r = RW'(MAX_HEIGHT - 1);
    end else begin
      last_r = RW'(h_ext - 1'b1);
    end
  end

  assign pix.ready = !out_valid_q || res.ready;
  assign acc       = pix.valid && pix.ready;
  assign star      = (pix.pixel_byte == STAR_CODE);
  assign c_first   = (col_q == '0);
  assign up_ok     = (row_q != '0);
  assign last_col  = (col_q >= last_c);
  assign last_row  = (row_q >= last_r);
  assign is_col1   = ({1'b0, col_q} == (CW + 1)'(1));
  assign is_col2   = ({1'b0, col_q} == (CW + 1)'(2));
  assign rd_addr   = CW'({1'b0, col_q} + (CW + 1)'(2));

  always_comb begin
    ur_raw = use_head_q ? ur_head_q : (byp_q ? byp_data_q : ram_rdata);
    left   = c_first ? flag_t'('0) : left_q;
    ul     = (!c_first && up_ok) ? hold_q : flag_t'('0);
    up     = up_ok ? up_q : flag_t'('0);
    ur     = (up_ok && !last_col) ? ur_raw : flag_t'('0);

    any_star = left.star || ul.star || up.star || ur.star;
    inc      = star && !any_star;
    n_dec    = star ? (3'({2'b0, left.iso}) + 3'({2'b0, ul.iso})
                     + 3'({2'b0, up.iso}) + 3'({2'b0, ur.iso})) : 3'd0;
    cnt_dec  = (cnt_q > CNT_W'(n_dec)) ? (cnt_q - CNT_W'(n_dec)) : '0;
    cnt_new  = (inc && (cnt_dec != COUNT_MAX)) ? (cnt_dec + 1'b1) : cnt_dec;

    fresh.star = star;
    fresh.iso  = inc;
    wr_data    = (star && !c_first) ? clear_iso(left_q) : left_q;
    up_w       = star ? clear_iso(up) : up;
    ur_w       = star ? clear_iso(ur) : ur;

    if (c_first) begin
      final0 = fresh;
    end else if (is_col1) begin
      final0 = wr_data;
    end else begin
      final0 = head0_q;
    end
    if (is_col1) begin
      final1 = fresh;
    end else if (is_col2) begin
      final1 = wr_data;
    end else begin
      final1 = head1_q;
    end
  end

  ipc_ram #(
    .WIDTH ($bits(flag_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (prev_col_q),
    .wdata_i (wr_data),
    .re_i    (acc),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      prev_col_q  <= '0;
      left_q      <= '0;
      hold_q      <= '0;
      use_head_q  <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        prev_col_q <= col_q;
        left_q     <= fresh;
        hold_q     <= last_col ? flag_t'('0) : up_w;
        use_head_q <= last_col;
        byp_q      <= (rd_addr == prev_col_q);
        if (last_col) begin
          col_q <= '0;
          if (last_row) begin
            row_q <= '0;
            cnt_q <= '0;
          end else begin
            row_q <= row_q + 1'b1;
            cnt_q <= cnt_new;
          end
        end else begin
          col_q <= col_q + 1'b1;
          cnt_q <= cnt_new;
        end
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      up_q       <= last_col ? final0 : ur_w;
      ur_head_q  <= final1;
      byp_data_q <= wr_data;
      out_cnt_q  <= cnt_new;
      out_done_q <= last_col && last_row;
      if (is_col1) begin
        head0_q <= wr_data;
      end
      if (is_col2) begin
        head1_q <= wr_data;
      end
    end
  end

  assign res.valid          = out_valid_q;
  assign res.isolated_count = out_cnt_q;
  assign res.frame_done     = out_done_q;

`ifndef SYNTHESIS
  a_frame_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_col && last_row |=> cnt_q == '0)
    else $error("count not cleared after the last pixel of a frame");

  a_col_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !last_col |=> col_q == CW'($past(col_q) + 1'b1))
    else $error("column did not advance by one");

  a_wr_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q != '0 |-> prev_col_q == CW'(col_q - 1'b1))
    else $error("line store write address is not the left neighbor");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q && !acc |=> !out_valid_q)
    else $error("result appeared without an input transfer");
`endif

endmodule

`default_nettype wire

// ----- src/isolated_pixel_counter.sv -----
// Top level of the isolated pixel counter: APB geometry registers and the update engine.
// A pixel's result is registered and presented in the cycle after its input transfer.
// Throughput: one pixel per cycle while no pending result waits on res_o.ready; set
// by the single-write line-store RAM doing one deferred write and one lookahead read per pixel.
// Reset clears the row and column positions, the running count and result valid flag;
// geometry returns to 100 by 100. The line store is not cleared: each row is written
// before the next row reads it.
`default_nettype none

module isolated_pixel_counter #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  ipc_pixel_if.sink                           pix_i,
  ipc_result_if.source                        res_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ipc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ipc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ipc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import ipc_pkg::*;

  geom_t geom;

  ipc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom_o  (geom)
  );

  ipc_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .geom_i (geom),
    .pix    (pix_i),
    .res    (res_o)
  );

endmodule

`default_nettype wire
